FILE: src/pfat_pkg.sv
// Shared widths, status codes and register map of the paged frame allocator.
`default_nettype none
package pfat_pkg;

    // Field widths of one request and one response
    localparam int unsigned SizeW = 23;
    localparam int unsigned ProcW = 5;
    localparam int unsigned PageW = 6;
    localparam int unsigned OffW  = 16;
    localparam int unsigned StW   = 3;
    localparam int unsigned FrmW  = 6;
    localparam int unsigned AddrW = 22;

    // Configuration register widths and reset values
    localparam int unsigned FcountW = 7;
    localparam int unsigned PsizeW  = 17;
    localparam logic [FcountW-1:0] FcountReset = 7'd64;
    localparam logic [PsizeW-1:0]  PsizeReset  = 17'd4096;

    // Request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_XLATE = 1'b1;

    // Register index taken from paddr bit 2
    localparam logic REG_FCOUNT = 1'b0;
    localparam logic REG_PSIZE  = 1'b1;

    // Response status codes
    typedef enum logic [StW-1:0] {
        ST_MAPPED     = 3'd0,
        ST_XLATED     = 3'd1,
        ST_BAD_OFFSET = 3'd2,
        ST_BAD_PROC   = 3'd3,
        ST_UNMAPPED   = 3'd4,
        ST_NO_FRAMES  = 3'd5,
        ST_NO_PROCS   = 3'd6
    } t_status;

endpackage
`default_nettype wire

FILE: src/pfat_req_if.sv
// Request channel: valid/ready handshake with the request fields.
`default_nettype none
interface pfat_req_if
    import pfat_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             kind;
    logic [SizeW-1:0] request_size;
    logic [ProcW-1:0] process_id;
    logic [PageW-1:0] page_number;
    logic [OffW-1:0]  page_offset;

    modport source (output valid, kind, request_size, process_id, page_number,
                    page_offset, input ready);
    modport sink   (input valid, kind, request_size, process_id, page_number,
                    page_offset, output ready);
endinterface
`default_nettype wire

FILE: src/pfat_rsp_if.sv
// Response channel: valid/ready handshake with the response fields.
`default_nettype none
interface pfat_rsp_if
    import pfat_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [StW-1:0]   status;
    logic [ProcW-1:0] assigned_process;
    logic [PageW-1:0] mapped_page;
    logic [FrmW-1:0]  frame_index;
    logic [AddrW-1:0] physical_address;
    logic             last;

    modport source (output valid, status, assigned_process, mapped_page, frame_index,
                    physical_address, last, input ready);
    modport sink   (input valid, status, assigned_process, mapped_page, frame_index,
                    physical_address, last, output ready);
endinterface
`default_nettype wire

FILE: src/pfat_divider.sv
// Restoring divider: request size over page size, one quotient bit per cycle.
`default_nettype none
module pfat_divider
    import pfat_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [SizeW-1:0]  i_dividend,
    input  wire logic [PsizeW-1:0] i_divisor,
    output logic                   o_done,
    output logic [SizeW-1:0]       o_quot
);
    localparam int unsigned CntW = $clog2(SizeW + 1);

    logic [CntW-1:0]   r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [PsizeW-1:0] r_div;
    logic [PsizeW-1:0] r_rem;
    logic [SizeW-1:0]  r_q;
    logic [PsizeW:0]   w_shift;
    logic              w_ge;

    // Shift in the next dividend bit and trial-subtract
    assign w_shift = {r_rem, r_q[SizeW-1]};
    assign w_ge    = (w_shift >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(SizeW);
                r_div  <= i_divisor;
                r_rem  <= '0;
                r_q    <= i_dividend;
            end else if (r_busy) begin
                if (w_ge) begin
                    r_rem <= PsizeW'(w_shift - {1'b0, r_div});
                end else begin
                    r_rem <= w_shift[PsizeW-1:0];
                end
                r_q   <= {r_q[SizeW-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule
`default_nettype wire

FILE: src/pfat_map_mem.sv
// Page table memory: one write port, one read port with registered data.
`default_nettype none
module pfat_map_mem #(
    parameter int unsigned AW = 10,
    parameter int unsigned DW = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    // Write the entry, register the read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

FILE: src/paged_frame_allocator_translator.sv
// Top level: request sequencer, frame scan, page table and APB registers.
//
// After reset a clearing pass over all MAX_FRAMES frames frees every frame before
// the first request is taken. A translate reads the page table entry from a
// synchronous memory, then frame * the page size + offset is formed and
// registered into the response. Error responses are loaded into the response
// register from S_SEND. An allocate first finds the page count (a restoring
// divider, one quotient bit per cycle), then counts the free live frames, then
// in each placement round finds the largest free run (the frame map is a
// synchronous memory read one frame per cycle) and maps pages into it one at a
// time. One request is in work at a time; the response register lets the
// next request in while the last response still waits. The page table needs
// no clearing after reset: a per-process page count marks which entries hold a
// mapping.
`default_nettype none
module paged_frame_allocator_translator
    import pfat_pkg::*;
#(
    parameter int unsigned MAX_FRAMES    = 64,
    parameter int unsigned MAX_PROCESSES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    pfat_req_if.sink         i_req,
    pfat_rsp_if.source       o_rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    localparam int unsigned FIW = $clog2(MAX_FRAMES);
    localparam int unsigned FCW = $clog2(MAX_FRAMES + 1);
    localparam int unsigned PIW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int unsigned TW  = $clog2(MAX_PROCESSES + 1);
    localparam int unsigned AW  = PIW + FIW;
    localparam int unsigned PW  = (FIW + PsizeW + 1 > AddrW) ? FIW + PsizeW + 1 : AddrW;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_DIV, S_CNT, S_SCAN, S_MAP, S_SEND, S_TRD, S_TRM
    } t_state;

    t_state            r_state;
    logic [FcountW-1:0] r_fcount;
    logic [PsizeW-1:0] r_psize;
    logic [TW-1:0]     r_total;
    logic [FCW-1:0]    r_pcnt [MAX_PROCESSES];
    logic [ProcW-1:0]  r_proc;
    logic [PIW-1:0]    r_pidx;
    logic [OffW-1:0]   r_off;
    logic [SizeW-1:0]  r_pages;
    logic [FCW-1:0]    r_free;
    logic [FCW-1:0]    r_i;
    logic              r_rv;
    logic [FCW-1:0]    r_run;
    logic [FCW-1:0]    r_runstart;
    logic [FCW-1:0]    r_best;
    logic [FCW-1:0]    r_start;
    logic [FCW-1:0]    r_m;
    logic [FCW-1:0]    r_done;
    logic [FIW-1:0]    r_fr;
    t_status           r_pst;

    logic              r_o_valid;
    t_status           r_o_status;
    logic [ProcW-1:0]  r_o_proc;
    logic [PageW-1:0]  r_o_page;
    logic [FrmW-1:0]   r_o_frame;
    logic [AddrW-1:0]  r_o_addr;
    logic              r_o_last;

    logic [FCW-1:0]    w_live;
    logic              w_free;
    logic              w_load;
    logic              w_acc;
    logic [PIW-1:0]    w_in_pidx;
    logic [FIW-1:0]    w_in_fidx;
    logic              w_bad_off;
    logic              w_bad_proc;
    logic              w_unmapped;
    logic              w_div_start;
    logic              w_div_done;
    logic [SizeW-1:0]  w_quot;
    logic              w_we;
    logic [FIW-1:0]    w_map_fr;
    logic [FIW-1:0]    w_rdata;
    logic              w_fu_we;
    logic [FIW-1:0]    w_fu_waddr;
    logic              w_fu_wdata;
    logic              w_fu_rdata;
    logic [PW-1:0]     w_paddr;
    logic              w_cfg_wr;

    // Clamp frame_count to the frames built
    always_comb begin
        if (32'(r_fcount) > 32'(MAX_FRAMES)) begin
            w_live = FCW'(MAX_FRAMES);
        end else begin
            w_live = FCW'(r_fcount);
        end
    end

    assign w_free  = !r_o_valid || o_rsp.ready;
    assign w_load  = ((r_state == S_MAP) || (r_state == S_SEND) || (r_state == S_TRM)) &&
                     w_free;
    assign i_req.ready = (r_state == S_IDLE);
    assign w_acc   = i_req.valid && (r_state == S_IDLE);

    // Translate checks, in priority order
    assign w_in_pidx  = PIW'(i_req.process_id - 5'd1);
    assign w_in_fidx  = FIW'(i_req.page_number);
    assign w_bad_off  = ({1'b0, i_req.page_offset} >= r_psize);
    assign w_bad_proc = (i_req.process_id == '0) ||
                        (32'(i_req.process_id) > 32'(r_total));
    assign w_unmapped = (32'(i_req.page_number) >= 32'(MAX_FRAMES)) ||
                        (32'(i_req.page_number) >= 32'(r_pcnt[w_in_pidx]));

    assign w_div_start = w_acc && (i_req.kind == KIND_ALLOC) &&
                         (32'(r_total) < 32'(MAX_PROCESSES)) && (r_psize != '0);

    pfat_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (i_req.request_size),
        .i_divisor  (r_psize),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // Page table write while mapping, read on translate accept
    assign w_map_fr = FIW'(r_start + r_m);
    assign w_we     = (r_state == S_MAP) && w_free;

    pfat_map_mem #(.AW(AW), .DW(FIW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr ({r_pidx, FIW'(r_done)}),
        .i_wdata (w_map_fr),
        .i_raddr ({w_in_pidx, w_in_fidx}),
        .o_rdata (w_rdata)
    );

    // Frame map: cleared after reset, marked while mapping, scanned one frame a cycle
    assign w_fu_we    = (r_state == S_CLR) || w_we;
    assign w_fu_waddr = (r_state == S_CLR) ? r_i[FIW-1:0] : w_map_fr;
    assign w_fu_wdata = (r_state != S_CLR);

    pfat_map_mem #(.AW(FIW), .DW(1)) u_frames (
        .i_clk   (i_clk),
        .i_we    (w_fu_we),
        .i_waddr (w_fu_waddr),
        .i_wdata (w_fu_wdata),
        .i_raddr (r_i[FIW-1:0]),
        .o_rdata (w_fu_rdata)
    );

    assign w_paddr  = PW'(r_fr) * PW'(r_psize) + PW'(r_off);
    assign w_cfg_wr = psel && penable && pwrite;

    // Sequencer, counters and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_i       <= '0;
            r_fcount  <= FcountReset;
            r_psize   <= PsizeReset;
            r_total   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                unique case (paddr[2])
                    REG_FCOUNT: r_fcount <= pwdata[FcountW-1:0];
                    REG_PSIZE:  r_psize  <= pwdata[PsizeW-1:0];
                    default:    r_fcount <= r_fcount;
                endcase
            end
            // Load a new transfer or drop the one taken
            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    if (r_i == FCW'(MAX_FRAMES - 1)) begin
                        r_state <= S_IDLE;
                    end
                    r_i <= r_i + 1'b1;
                end
                S_IDLE: begin
                    if (w_acc) begin
                        r_off  <= i_req.page_offset;
                        if (i_req.kind == KIND_ALLOC) begin
                            if (32'(r_total) >= 32'(MAX_PROCESSES)) begin
                                r_pst   <= ST_NO_PROCS;
                                r_proc  <= '0;
                                r_state <= S_SEND;
                            end else begin
                                r_total <= r_total + 1'b1;
                                r_proc  <= ProcW'(r_total + 1'b1);
                                r_pidx  <= PIW'(r_total);
                                r_pcnt[PIW'(r_total)] <= '0;
                                r_state <= (r_psize != '0) ? S_DIV : S_IDLE;
                            end
                        end else begin
                            r_proc <= i_req.process_id;
                            priority if (w_bad_off) begin
                                r_pst   <= ST_BAD_OFFSET;
                                r_state <= S_SEND;
                            end else if (w_bad_proc) begin
                                r_pst   <= ST_BAD_PROC;
                                r_state <= S_SEND;
                            end else if (w_unmapped) begin
                                r_pst   <= ST_UNMAPPED;
                                r_state <= S_SEND;
                            end else begin
                                r_state <= S_TRD;
                            end
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_pages <= w_quot;
                        r_i     <= '0;
                        r_rv    <= 1'b0;
                        r_free  <= '0;
                        r_state <= (w_quot == '0) ? S_IDLE : S_CNT;
                    end
                end
                S_CNT: begin
                    if ((r_i == w_live) && !r_rv) begin
                        if (32'(r_pages) > 32'(r_free)) begin
                            r_pst   <= ST_NO_FRAMES;
                            r_state <= S_SEND;
                        end else begin
                            r_done     <= '0;
                            r_i        <= '0;
                            r_run      <= '0;
                            r_runstart <= '0;
                            r_best     <= '0;
                            r_start    <= '0;
                            r_state    <= S_SCAN;
                        end
                    end else begin
                        // Count the frame read last cycle, issue the next read
                        if (r_rv && !w_fu_rdata) begin
                            r_free <= r_free + 1'b1;
                        end
                        if (r_i != w_live) begin
                            r_i  <= r_i + 1'b1;
                            r_rv <= 1'b1;
                        end else begin
                            r_rv <= 1'b0;
                        end
                    end
                end
                S_SCAN: begin
                    // Track the largest free run; first run wins a tie
                    if ((r_i == w_live) && !r_rv) begin
                        if (r_run > r_best) begin
                            r_best  <= r_run;
                            r_start <= r_runstart;
                        end
                        r_m     <= '0;
                        r_state <= S_MAP;
                    end else begin
                        // The frame read last cycle is r_i - 1
                        if (r_rv) begin
                            if (!w_fu_rdata) begin
                                r_run <= r_run + 1'b1;
                            end else begin
                                if (r_run > r_best) begin
                                    r_best  <= r_run;
                                    r_start <= r_runstart;
                                end
                                r_run      <= '0;
                                r_runstart <= r_i;
                            end
                        end
                        if (r_i != w_live) begin
                            r_i  <= r_i + 1'b1;
                            r_rv <= 1'b1;
                        end else begin
                            r_rv <= 1'b0;
                        end
                    end
                end
                S_MAP: begin
                    if (w_free) begin
                        r_o_status <= ST_MAPPED;
                        r_o_proc   <= r_proc;
                        r_o_page   <= PageW'(r_done);
                        r_o_frame  <= FrmW'(w_map_fr);
                        r_o_addr   <= '0;
                        r_o_last   <= (32'(r_done) + 32'd1 == 32'(r_pages));
                        r_done     <= r_done + 1'b1;
                        r_m        <= r_m + 1'b1;
                        if (32'(r_done) + 32'd1 == 32'(r_pages)) begin
                            r_pcnt[r_pidx] <= FCW'(r_pages);
                            r_state        <= S_IDLE;
                        end else if (r_m + 1'b1 == r_best) begin
                            r_i        <= '0;
                            r_rv       <= 1'b0;
                            r_run      <= '0;
                            r_runstart <= '0;
                            r_best     <= '0;
                            r_start    <= '0;
                            r_state    <= S_SCAN;
                        end
                    end
                end
                S_SEND: begin
                    if (w_free) begin
                        r_o_status <= r_pst;
                        r_o_proc   <= r_proc;
                        r_o_page   <= '0;
                        r_o_frame  <= '0;
                        r_o_addr   <= '0;
                        r_o_last   <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                S_TRD: begin
                    r_fr    <= w_rdata;
                    r_state <= S_TRM;
                end
                S_TRM: begin
                    if (w_free) begin
                        r_o_status <= ST_XLATED;
                        r_o_proc   <= r_proc;
                        r_o_page   <= '0;
                        r_o_frame  <= FrmW'(r_fr);
                        r_o_addr   <= w_paddr[AddrW-1:0];
                        r_o_last   <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Drive the response channel
    assign o_rsp.valid            = r_o_valid;
    assign o_rsp.status           = r_o_status;
    assign o_rsp.assigned_process = r_o_proc;
    assign o_rsp.mapped_page      = r_o_page;
    assign o_rsp.frame_index      = r_o_frame;
    assign o_rsp.physical_address = r_o_addr;
    assign o_rsp.last             = r_o_last;

    // Register readback
    assign pready = 1'b1;
    always_comb begin
        unique case (paddr[2])
            REG_FCOUNT: prdata = 32'(r_fcount);
            REG_PSIZE:  prdata = 32'(r_psize);
            default:    prdata = '0;
        endcase
    end
endmodule
`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the paged frame allocator and address translator.
`default_nettype none
module testbench;
    import pfat_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NFRAMES    = 64;
    localparam int unsigned NPROCS     = 16;
    localparam int unsigned SETTLE     = 400;
    localparam int unsigned CYCLE_CAP  = 1000000;

    typedef struct packed {
        logic             kind;
        logic [SizeW-1:0] size;
        logic [ProcW-1:0] proc;
        logic [PageW-1:0] page;
        logic [OffW-1:0]  off;
    } req_item_t;

    typedef struct packed {
        t_status          status;
        logic [ProcW-1:0] proc;
        logic [PageW-1:0] page;
        logic [FrmW-1:0]  frame;
        logic [AddrW-1:0] addr;
        logic             last;
    } rsp_item_t;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pfat_req_if req_bus ();
    pfat_rsp_if rsp_bus ();

    paged_frame_allocator_translator uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow state of the allocator
    logic [FcountW-1:0] cfg_fcount;
    logic [PsizeW-1:0]  cfg_psize;
    logic               frame_busy [NFRAMES];
    logic               page_live  [NPROCS*NFRAMES];
    logic [FrmW-1:0]    page_frame [NPROCS*NFRAMES];
    int unsigned        proc_count;

    req_item_t pending_reqs[$];
    rsp_item_t expected_rsps[$];
    int unsigned error_count;
    int unsigned accepted_count;
    int unsigned cycle_count;
    int unsigned hold_cycles;
    logic        hold_done;

    // Clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    function automatic rsp_item_t make_rsp(t_status st, logic [ProcW-1:0] p, logic [PageW-1:0] pg,
                                           logic [FrmW-1:0] fr, logic [AddrW-1:0] a, logic l);
        rsp_item_t r;
        r.status = st; r.proc = p; r.page = pg; r.frame = fr; r.addr = a; r.last = l;
        return r;
    endfunction

    // Place the pages of a new process into the largest free runs
    task automatic predict_alloc(input logic [SizeW-1:0] size);
        int unsigned n, pages, freecnt, done, base, best, start, run, runstart, take;
        logic [ProcW-1:0] p;
        n = (cfg_fcount > NFRAMES) ? NFRAMES : cfg_fcount;
        if (proc_count >= NPROCS) begin
            expected_rsps.push_back(make_rsp(ST_NO_PROCS, '0, '0, '0, '0, 1'b1));
            return;
        end
        proc_count++;
        p = proc_count[ProcW-1:0];
        base = (proc_count - 1) * NFRAMES;
        pages = (cfg_psize == 0) ? 0 : size / cfg_psize;
        if (pages == 0) return;
        freecnt = 0;
        for (int i = 0; i < n; i++) if (!frame_busy[i]) freecnt++;
        if (pages > freecnt) begin
            expected_rsps.push_back(make_rsp(ST_NO_FRAMES, p, '0, '0, '0, 1'b1));
            return;
        end
        done = 0;
        while (done < pages) begin
            best = 0; start = 0; run = 0; runstart = 0;
            for (int i = 0; i < n; i++) begin
                if (!frame_busy[i]) begin
                    run++;
                end else begin
                    if (run > best) begin
                        best = run; start = runstart;
                    end
                    run = 0; runstart = i + 1;
                end
            end
            if (run > best) begin
                best = run; start = runstart;
            end
            take = pages - done;
            if (take > best) take = best;
            for (int m = 0; m < take; m++) begin
                frame_busy[start+m] = 1'b1;
                page_live[base+done] = 1'b1;
                page_frame[base+done] = FrmW'(start + m);
                expected_rsps.push_back(make_rsp(ST_MAPPED, p, PageW'(done), FrmW'(start + m),
                                                 '0, done + 1 == pages));
                done++;
            end
        end
    endtask

    // Check offset, then process, then page
    task automatic predict_xlate(input req_item_t it);
        int unsigned idx;
        logic [39:0] a;
        if (it.off >= cfg_psize)
            expected_rsps.push_back(make_rsp(ST_BAD_OFFSET, it.proc, '0, '0, '0, 1'b1));
        else if (it.proc == 0 || it.proc > proc_count)
            expected_rsps.push_back(make_rsp(ST_BAD_PROC, it.proc, '0, '0, '0, 1'b1));
        else begin
            idx = (it.proc - 1) * NFRAMES + it.page;
            if (!page_live[idx])
                expected_rsps.push_back(make_rsp(ST_UNMAPPED, it.proc, '0, '0, '0, 1'b1));
            else begin
                a = page_frame[idx] * cfg_psize + it.off;
                expected_rsps.push_back(make_rsp(ST_XLATED, it.proc, '0, page_frame[idx],
                                                 a[AddrW-1:0], 1'b1));
            end
        end
    endtask

    function automatic int unsigned sender_idle_pct();
        if (accepted_count < 140) return 16;
        if (accepted_count < 280) return 46;
        return 0;
    endfunction

    function automatic int unsigned receiver_idle_pct();
        if (accepted_count < 140) return 46;
        if (accepted_count < 280) return 16;
        return 0;
    endfunction

    // Driver: offer queued requests, predict each transfer
    always @(posedge i_clk) begin
        req_item_t nxt;
        if (i_rst_n) begin
            if (req_bus.valid && req_bus.ready) begin
                accepted_count++;
                if (req_bus.kind == KIND_ALLOC) predict_alloc(req_bus.request_size);
                else predict_xlate({req_bus.kind, req_bus.request_size, req_bus.process_id,
                                    req_bus.page_number, req_bus.page_offset});
            end
            if (!req_bus.valid || req_bus.ready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
                    nxt = pending_reqs.pop_front();
                    req_bus.valid        <= 1'b1;
                    req_bus.kind         <= nxt.kind;
                    req_bus.request_size <= nxt.size;
                    req_bus.process_id   <= nxt.proc;
                    req_bus.page_number  <= nxt.page;
                    req_bus.page_offset  <= nxt.off;
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off once traffic is flowing
    always @(posedge i_clk) begin
        if (hold_cycles != 0) hold_cycles <= hold_cycles - 1;
        else if (!hold_done && accepted_count >= 60) begin
            hold_cycles <= 600;
            hold_done   <= 1'b1;
        end
    end

    // Receiver ready with random stalls
    always @(posedge i_clk) begin
        logic rdy;
        rdy = (hold_cycles == 0) && ($urandom_range(99) >= receiver_idle_pct());
        rsp_bus.ready <= rdy;
    end

    // Monitor: compare each response transfer with the oldest expectation
    always @(posedge i_clk) begin
        rsp_item_t want;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (expected_rsps.size() == 0) begin
                report("unexpected response status", 32'(rsp_bus.status), 32'd0);
            end else begin
                want = expected_rsps.pop_front();
                if (rsp_bus.status !== want.status)
                    report("status", 32'(rsp_bus.status), 32'(want.status));
                if (rsp_bus.assigned_process !== want.proc)
                    report("assigned_process", 32'(rsp_bus.assigned_process), 32'(want.proc));
                if (rsp_bus.mapped_page !== want.page)
                    report("mapped_page", 32'(rsp_bus.mapped_page), 32'(want.page));
                if (rsp_bus.frame_index !== want.frame)
                    report("frame_index", 32'(rsp_bus.frame_index), 32'(want.frame));
                if (rsp_bus.physical_address !== want.addr)
                    report("physical_address", 32'(rsp_bus.physical_address), 32'(want.addr));
                if (rsp_bus.last !== want.last)
                    report("last", 32'(rsp_bus.last), 32'(want.last));
            end
        end
    end

    // Timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic reg_write(input logic ridx, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {ridx, 2'b00}; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (ridx == REG_FCOUNT) cfg_fcount = value[FcountW-1:0];
        else cfg_psize = value[PsizeW-1:0];
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || req_bus.valid || expected_rsps.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic req_item_t alloc_item(input logic [SizeW-1:0] size);
        req_item_t it;
        it = '0; it.kind = KIND_ALLOC; it.size = size;
        return it;
    endfunction

    function automatic req_item_t xlate_item(input int unsigned p, input int unsigned pg,
                                             input int unsigned o);
        req_item_t it;
        it.kind = KIND_XLATE; it.size = SizeW'($urandom);
        it.proc = ProcW'(p); it.page = PageW'(pg); it.off = OffW'(o);
        return it;
    endfunction

    // Mostly well-formed translates of live processes, some allocates and noise
    function automatic req_item_t random_item();
        int unsigned r, ps;
        r = $urandom_range(99);
        ps = (cfg_psize == 0) ? 1 : cfg_psize;
        if (r < 8)
            return alloc_item(SizeW'($urandom_range(6) * ps + $urandom_range(ps - 1)));
        if (r < 12) return alloc_item(SizeW'($urandom));
        if (r < 22) return xlate_item($urandom, $urandom, $urandom);
        return xlate_item($urandom_range(proc_count + 1), $urandom_range(7),
                          (ps > 65536) ? $urandom_range(65535) : $urandom_range(ps - 1));
    endfunction

    task automatic random_batch(input int unsigned count);
        repeat (count) pending_reqs.push_back(random_item());
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        req_bus.valid = 1'b0; req_bus.kind = KIND_ALLOC; req_bus.request_size = '0;
        req_bus.process_id = '0; req_bus.page_number = '0; req_bus.page_offset = '0;
        rsp_bus.ready = 1'b0;
        error_count = 0; accepted_count = 0; cycle_count = 0;
        hold_cycles = 0; hold_done = 1'b0;
        cfg_fcount = FcountReset; cfg_psize = PsizeReset; proc_count = 0;
        for (int i = 0; i < NFRAMES; i++) frame_busy[i] = 1'b0;
        for (int i = 0; i < NPROCS*NFRAMES; i++) begin
            page_live[i] = 1'b0; page_frame[i] = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: directed corners
        pending_reqs.push_back(xlate_item(1, 0, 0));
        pending_reqs.push_back(xlate_item(0, 0, 0));
        pending_reqs.push_back(alloc_item(0));
        pending_reqs.push_back(alloc_item(3 * 4096 + 5));
        pending_reqs.push_back(xlate_item(2, 0, 0));
        pending_reqs.push_back(xlate_item(2, 2, 4095));
        pending_reqs.push_back(xlate_item(2, 1, 4096));
        pending_reqs.push_back(xlate_item(2, 3, 7));
        pending_reqs.push_back(xlate_item(2, 63, 0));
        pending_reqs.push_back(xlate_item(3, 0, 0));
        pending_reqs.push_back(xlate_item(31, 0, 0));
        pending_reqs.push_back(xlate_item(2, 0, 65535));
        pending_reqs.push_back(alloc_item(4194304));
        pending_reqs.push_back(alloc_item(23'h7FFFFF));
        pending_reqs.push_back(alloc_item(4095));
        random_batch(110);
        drain();

        // Tiny pages over a few frames
        reg_write(REG_FCOUNT, 10);
        reg_write(REG_PSIZE, 1);
        pending_reqs.push_back(alloc_item(2));
        pending_reqs.push_back(xlate_item(proc_count + 1, 1, 0));
        pending_reqs.push_back(xlate_item(proc_count + 1, 0, 1));
        random_batch(60);
        drain();

        // No usable frames
        reg_write(REG_FCOUNT, 0);
        reg_write(REG_PSIZE, 7);
        pending_reqs.push_back(alloc_item(7));
        random_batch(20);
        drain();

        // Frame count above the table, largest legal page
        reg_write(REG_FCOUNT, 127);
        reg_write(REG_PSIZE, 65536);
        pending_reqs.push_back(alloc_item(5 * 65536));
        pending_reqs.push_back(xlate_item(proc_count + 1, 4, 65535));
        random_batch(100);
        drain();

        // Oversized page: addresses wrap
        reg_write(REG_FCOUNT, 64);
        reg_write(REG_PSIZE, 131071);
        random_batch(40);
        drain();

        // Zero page size: every offset is out of range
        reg_write(REG_PSIZE, 0);
        pending_reqs.push_back(alloc_item(100));
        random_batch(20);
        drain();

        // Odd page size, a fresh fill of processes is exhausted by now
        reg_write(REG_FCOUNT, 1);
        reg_write(REG_PSIZE, 300);
        random_batch(60);
        drain();

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: sim.f
src/pfat_pkg.sv
src/pfat_req_if.sv
src/pfat_rsp_if.sv
src/pfat_divider.sv
src/pfat_map_mem.sv
src/paged_frame_allocator_translator.sv
dv/testbench.sv
